// File: rtl/core/sha512_block_compress_top_assert.svh
// Assertion macros for the SHA-512 block compression top level.
`ifndef SHA512_BLOCK_COMPRESS_TOP_ASSERT_SVH
`define SHA512_BLOCK_COMPRESS_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SBC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sbc_pkg.sv
// Shared types, constants and SHA-512 functions for the block compression core.
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int NUM_CHAIN   = 8;
  localparam int BLOCK_WORDS = 16;
  localparam int NUM_ROUNDS  = 80;

  typedef struct packed {
    logic [63:0] message_word;
    logic        start_message;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_word_t;

  // Controls from the sequencer to the message schedule.
  typedef struct packed {
    logic       coll_we;
    logic [3:0] coll_addr;
    logic       step;
    logic [6:0] idx;
  } sched_ctl_t;

  // Controls from the sequencer to the compression datapath.
  typedef struct packed {
    logic [2:0] rd_addr;
    logic       wr_en;
    logic [2:0] wr_addr;
    logic       wr_init;
    logic       load_shift;
    logic       round_en;
    logic       emit;
  } cmp_ctl_t;

  localparam logic [63:0] ROUND_K [NUM_ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] round_k(input logic [6:0] idx);
    logic [63:0] k;
    k = '0;
    if (idx < 7'(NUM_ROUNDS)) k = ROUND_K[idx];
    return k;
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] x);
    return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] x);
    return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] x);
    return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] x);
    return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
  endfunction

endpackage

// File: rtl/core/sbc_cfg_regs.sv
// APB register bank holding the eight initial chaining words.
`timescale 1ns / 1ps

module sbc_cfg_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic [2:0]  copy_idx,
  output logic [63:0] init_word
);

  logic [63:0] init_r [sbc_pkg::NUM_CHAIN];
  logic        wr_hit;
  logic [2:0]  reg_idx;

  assign reg_idx = paddr[5:3];
  assign wr_hit  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbc_pkg::NUM_CHAIN; i++) init_r[i] <= '0;
    end else if (wr_hit) begin
      init_r[reg_idx] <= pwdata;
    end
  end

  assign prdata    = init_r[reg_idx];
  assign init_word = init_r[copy_idx];

endmodule

// File: rtl/core/sbc_sched.sv
// Message schedule: 16-word window memory and one-word-per-cycle expansion.
`timescale 1ns / 1ps

module sbc_sched (
  input  logic                clk,
  input  sbc_pkg::sched_ctl_t ctl,
  input  logic [63:0]         coll_data,
  output logic [63:0]         wk
);

  logic [63:0] sched_mem_r [sbc_pkg::BLOCK_WORDS];
  logic [63:0] rd_a_r, rd_b_r;
  logic [63:0] m16_r, w1_r, w2_r, wk_r;
  logic [3:0]  addr_a, addr_b;
  logic        expand;
  logic [63:0] w_new;

  // Reads run one step ahead: port A fetches w[t-15] (it becomes w[t-16] once
  // copied into m16_r), port B fetches w[t-7]. Neither ever hits the entry being
  // written, so no forwarding is needed.
  assign addr_a = ctl.idx[3:0] + 4'd2;
  assign addr_b = ctl.idx[3:0] + 4'd10;
  assign expand = |ctl.idx[6:4];

  assign w_new = expand ? (m16_r + sbc_pkg::small_sigma0(rd_a_r) + rd_b_r
                           + sbc_pkg::small_sigma1(w2_r))
                        : m16_r;

  always_ff @(posedge clk) begin
    if (ctl.coll_we) begin
      sched_mem_r[ctl.coll_addr] <= coll_data;
    end else if (ctl.step && expand) begin
      sched_mem_r[ctl.idx[3:0]] <= w_new;
    end
    rd_a_r <= sched_mem_r[addr_a];
    rd_b_r <= sched_mem_r[addr_b];
  end

  always_ff @(posedge clk) begin
    m16_r <= rd_a_r;
    if (ctl.step) begin
      w1_r <= w_new;
      w2_r <= w1_r;
      wk_r <= w_new + sbc_pkg::round_k(ctl.idx);
    end
  end

  assign wk = wk_r;

endmodule

// File: rtl/core/sbc_compress.sv
// Chaining-word memory, working variables, round logic and result register.
`timescale 1ns / 1ps

module sbc_compress (
  input  logic               clk,
  input  logic               rst_n,
  input  sbc_pkg::cmp_ctl_t  ctl,
  input  logic [63:0]        wk,
  input  logic [63:0]        init_word,
  output logic               out_strobe,
  output sbc_pkg::out_word_t out_word
);

  logic [63:0] chain_mem_r [sbc_pkg::NUM_CHAIN];
  logic [63:0] chain_rd_r;
  logic        chain_zero_r;
  logic [63:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic        out_strobe_r;
  sbc_pkg::out_word_t out_word_r;

  logic [63:0] chain_rd, digest_sum, wr_data, t1, t2;

  // Until the first reload or block, every chaining word reads as zero.
  assign chain_rd   = chain_zero_r ? 64'd0 : chain_rd_r;
  assign digest_sum = chain_rd + a_r;
  assign wr_data    = ctl.wr_init ? init_word : digest_sum;

  assign t1 = h_r + sbc_pkg::big_sigma1(e_r) + ((e_r & f_r) ^ (~e_r & g_r)) + wk;
  assign t2 = sbc_pkg::big_sigma0(a_r) + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));

  always_ff @(posedge clk) begin
    if (ctl.wr_en) chain_mem_r[ctl.wr_addr] <= wr_data;
    chain_rd_r <= chain_mem_r[ctl.rd_addr];
  end

  // Both the reload sweep and the final add write entry h last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_zero_r <= 1'b1;
    end else if (ctl.wr_en && ctl.wr_addr == 3'(sbc_pkg::NUM_CHAIN - 1)) begin
      chain_zero_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_shift) begin
      // words arrive h first and shift toward h
      a_r <= chain_rd; b_r <= a_r; c_r <= b_r; d_r <= c_r;
      e_r <= d_r;      f_r <= e_r; g_r <= f_r; h_r <= g_r;
    end else if (ctl.round_en) begin
      a_r <= t1 + t2;  b_r <= a_r; c_r <= b_r; d_r <= c_r;
      e_r <= d_r + t1; f_r <= e_r; g_r <= f_r; h_r <= g_r;
    end else if (ctl.emit) begin
      // rotate so the next chaining word's partner sits in a
      a_r <= b_r; b_r <= c_r; c_r <= d_r; d_r <= e_r;
      e_r <= f_r; f_r <= g_r; g_r <= h_r; h_r <= a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_word_r.digest_word <= digest_sum;
      out_word_r.word_number <= ctl.wr_addr;
      out_word_r.last_word   <= (ctl.wr_addr == 3'(sbc_pkg::NUM_CHAIN - 1));
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// File: rtl/core/sha512_block_compress_top.sv
// SHA-512 block compression top level: sequencer and datapath wiring.
//
// Input: a word (message_word, start_message) is taken at a clock edge with
// start high and busy low. start_message reloads the chaining words from the
// eight APB registers (at 8*i) and makes the word the first of a block; busy
// stays high during the reload sweep. Words 1..15 can then be taken one per cycle.
// After the sixteenth word busy stays high while the sequencer loads the
// working variables from the chaining memory, runs the rounds (one round
// per cycle through the schedule and round datapath) and does the final adds.
// The eight updated chaining words a..h are registered from the final adds
// onto out_word, one per cycle with out_strobe high, last_word marking h.
// Results cannot be held off. No new word is taken until the final adds of a
// block are done. Reset clears the sequencer and the init registers and makes
// the chaining words read as zero; the schedule window holds nothing until
// written.
`timescale 1ns / 1ps
`include "sha512_block_compress_top_assert.svh"

module sha512_block_compress_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sbc_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output sbc_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_COPY    = 3'd1;
  localparam logic [2:0] S_LOAD    = 3'd2;
  localparam logic [2:0] S_ROUND   = 3'd3;
  localparam logic [2:0] S_FIN     = 3'd4;

  localparam logic [6:0] LAST_ROUND = 7'(sbc_pkg::NUM_ROUNDS);
  localparam logic [3:0] LAST_WORD  = 4'(sbc_pkg::BLOCK_WORDS - 1);

  logic [2:0] state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [3:0] wcnt_r, wcnt_nxt;
  logic       accept;
  logic [63:0] wk, init_word;

  sbc_pkg::sched_ctl_t sched_ctl;
  sbc_pkg::cmp_ctl_t   cmp_ctl;

  assign busy   = (state_r != S_COLLECT);
  assign accept = start & ~busy;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    wcnt_nxt  = wcnt_r;
    sched_ctl = '0;
    cmp_ctl   = '0;
    unique case (state_r)
      S_COLLECT: begin
        if (accept) begin
          sched_ctl.coll_we   = 1'b1;
          sched_ctl.coll_addr = in_word.start_message ? 4'd0 : wcnt_r;
          wcnt_nxt            = sched_ctl.coll_addr + 4'd1;
          cnt_nxt             = '0;
          if (in_word.start_message) begin
            state_nxt = S_COPY;
          end else if (wcnt_r == LAST_WORD) begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_COPY: begin
        cmp_ctl.wr_en   = 1'b1;
        cmp_ctl.wr_init = 1'b1;
        cmp_ctl.wr_addr = cnt_r[2:0];
        cnt_nxt         = cnt_r + 7'd1;
        if (cnt_r[2:0] == 3'd7) state_nxt = S_COLLECT;
      end
      S_LOAD: begin
        cmp_ctl.rd_addr    = ~cnt_r[2:0];
        cmp_ctl.load_shift = (cnt_r != 7'd0);
        // prime the schedule reads two steps ahead of step 0
        if (cnt_r == 7'd7) sched_ctl.idx = 7'd126;
        if (cnt_r == 7'd8) sched_ctl.idx = 7'd127;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd8) begin
          cnt_nxt   = '0;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        sched_ctl.step   = (cnt_r != LAST_ROUND);
        sched_ctl.idx    = cnt_r;
        cmp_ctl.round_en = (cnt_r != 7'd0);
        cnt_nxt          = cnt_r + 7'd1;
        if (cnt_r == LAST_ROUND) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmp_ctl.rd_addr = cnt_r[2:0];
        cmp_ctl.wr_addr = cnt_r[2:0] - 3'd1;
        cmp_ctl.wr_en   = (cnt_r != 7'd0);
        cmp_ctl.emit    = (cnt_r != 7'd0);
        cnt_nxt         = cnt_r + 7'd1;
        if (cnt_r == 7'd8) state_nxt = S_COLLECT;
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
      cnt_r   <= '0;
      wcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  sbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .copy_idx  (cmp_ctl.wr_addr),
    .init_word (init_word)
  );

  sbc_sched u_sched (
    .clk       (clk),
    .ctl       (sched_ctl),
    .coll_data (in_word.message_word),
    .wk        (wk)
  );

  sbc_compress u_compress (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (cmp_ctl),
    .wk         (wk),
    .init_word  (init_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  `SBC_ASSERT_NEXT(a_start_reload, accept && in_word.start_message, state_r == S_COPY, "start word did not begin reload")
  `SBC_ASSERT_NEXT(a_block_full, accept && !in_word.start_message && wcnt_r == LAST_WORD, state_r == S_LOAD, "full block did not start compression")
  `SBC_ASSERT_SAME(a_strobe_fin, out_strobe, $past(state_r == S_FIN), "result word outside final add")
  `SBC_ASSERT_SAME(a_last_idle, out_strobe && out_word.last_word, state_r == S_COLLECT, "last word while still busy")

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the SHA-512 block compression core.
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 2000;  // cycles with no word, digest or register write
  localparam int DRAIN_CYCLES = 110;  // covers the span from the 16th word to the last digest word
  localparam int REG_STRIDE = 8;
  localparam int NUM_IV = 8;

  typedef enum int {IV_ZERO, IV_ONES, IV_SHA512, IV_SHA384, IV_RANDOM} iv_set_t;

  localparam logic [63:0] K512 [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] IV512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] IV384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  sbc_pkg::in_word_t  in_word = '0;
  logic               out_strobe;
  sbc_pkg::out_word_t out_word;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [5:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  // predictor state
  logic [63:0] hash_iv [8];
  logic [63:0] chain_h [8];
  logic [63:0] msg_window [16];
  logic [3:0]  fill_idx;
  sbc_pkg::out_word_t digest_q [$];
  sbc_pkg::out_word_t head_w;

  bit gaps_on;
  int err_count = 0;
  int n_words = 0;
  int n_starts = 0;
  int n_checked = 0;
  int stall_cycles = 0;

  sha512_block_compress_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // 80 rounds over the collected block, fold into the chaining words, queue digest
  function automatic void compress_block();
    logic [63:0] w [16];
    logic [63:0] v [8];
    logic [63:0] x15, x2, t1, t2;
    sbc_pkg::out_word_t exp_w;
    int t;
    w = msg_window;
    v = chain_h;
    for (t = 0; t < 80; t++) begin
      if (t >= 16) begin
        x15 = w[(t + 1) % 16];
        x2 = w[(t + 14) % 16];
        w[t % 16] = w[t % 16] + (ror64(x15, 1) ^ ror64(x15, 8) ^ (x15 >> 7))
                  + w[(t + 9) % 16] + (ror64(x2, 19) ^ ror64(x2, 61) ^ (x2 >> 6));
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K512[t] + w[t % 16];
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      chain_h[i] = chain_h[i] + v[i];
      exp_w.digest_word = chain_h[i];
      exp_w.word_number = 3'(i);
      exp_w.last_word = (i == 7);
      digest_q.push_back(exp_w);
    end
  endfunction

  function automatic void absorb_word(input logic [63:0] w, input logic st);
    if (st) begin
      chain_h = hash_iv;
      fill_idx = '0;
    end
    msg_window[fill_idx] = w;
    fill_idx = fill_idx + 4'd1;
    if (fill_idx == 4'd0) compress_block();
  endfunction

  // one word through the start/busy handshake; start stays high for a back-to-back word
  task automatic send_word(input logic [63:0] w, input logic st);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1'b1;
    in_word.message_word <= w;
    in_word.start_message <= st;
    do @(negedge clk); while (busy);
    @(posedge clk);
    absorb_word(w, st);
    n_words++;
    if (st) n_starts++;
  endtask

  // drain: all digest words in, then room for a partial block's start sweep
  task automatic settle();
    start <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_iv(input iv_set_t sel);
    logic [63:0] val;
    for (int i = 0; i < NUM_IV; i++) begin
      case (sel)
        IV_ZERO:   val = '0;
        IV_ONES:   val = '1;
        IV_SHA512: val = IV512[i];
        IV_SHA384: val = IV384[i];
        default:   val = {$urandom, $urandom};
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 6'(i * REG_STRIDE);
      pwdata <= val;
      @(posedge clk);
      penable <= 1'b1;
      do @(negedge clk); while (!pready);
      @(posedge clk);
      hash_iv[i] = val;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // chaining words read as zero when no word has carried start since reset
  task automatic test_no_start_after_reset();
    logic [63:0] pat [6];
    pat = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'h1,
            64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555};
    for (int i = 0; i < 16; i++) send_word((i < 6) ? pat[i] : {$urandom, $urandom}, 1'b0);
  endtask

  // leaves three words pending; the next start must throw them away
  task automatic test_abandoned_block();
    send_word(64'h6162_6380_0000_0000, 1'b1);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
  endtask

  task automatic test_random_messages(input iv_set_t sel, input int n_items, input bit gaps);
    int target, kind, len;
    settle();
    program_iv(sel);
    gaps_on = gaps;
    target = n_words + n_items;
    while (n_words < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // well-formed message of one or two blocks
        len = 16 * $urandom_range(1, 2);
      end else if (kind == 7) begin
        // chained block, no start
        len = 16;
      end else begin
        // message cut short
        len = $urandom_range(1, 15);
      end
      if (len > target - n_words) len = target - n_words;
      for (int i = 0; i < len; i++) send_word(pick_word(), kind != 7 && i == 0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      n_checked++;
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h (word_number %0d)", out_word.digest_word,
               out_word.word_number);
        err_count++;
      end else begin
        head_w = digest_q.pop_front();
        if (out_word.digest_word !== head_w.digest_word) begin
          $error("digest_word: expected %h, got %h", head_w.digest_word, out_word.digest_word);
          err_count++;
        end
        if (out_word.word_number !== head_w.word_number) begin
          $error("word_number: expected %0d, got %0d", head_w.word_number,
                 out_word.word_number);
          err_count++;
        end
        if (out_word.last_word !== head_w.last_word) begin
          $error("last_word: expected %0b, got %0b", head_w.last_word, out_word.last_word);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable && pwrite))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) begin
      hash_iv[i] = '0;
      chain_h[i] = '0;
    end
    for (int i = 0; i < 16; i++) msg_window[i] = '0;
    fill_idx = '0;
    gaps_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_start_after_reset();
    test_abandoned_block();
    test_random_messages(IV_ONES, 40, 1'b1);
    test_random_messages(IV_SHA512, 40, 1'b1);
    test_random_messages(IV_SHA384, 40, 1'b1);
    test_random_messages(IV_RANDOM, 40, 1'b1);
    test_random_messages(IV_ZERO, 40, 1'b0);
    settle();

    $display("Sent %0d message words (%0d opening a message) under five IV settings;",
             n_words, n_starts);
    $display("compared %0d digest words against the predicted chaining words.", n_checked);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
